>>> sv/tdwq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdwq_pkg: shared types and constants of the tick delay wakeup queue
// Field widths, request and reply codes, and the command and status words
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tdwq_pkg;

  // Fixed field widths
  localparam int unsigned TIME_W   = 31;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned REQ_W    = 8;
  localparam int unsigned AMOUNT_W = 32;
  localparam int unsigned SDATA_W  = 40;  // requester, amount
  localparam int unsigned MDATA_W  = 40;  // target, time_value, one pad bit

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELAY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNTIL = 2'd3;

  // Reply kinds
  localparam logic [KIND_W-1:0] RK_WAKE = 2'd0;
  localparam logic [KIND_W-1:0] RK_TIME = 2'd1;
  localparam logic [KIND_W-1:0] RK_FULL = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic              capture;    // latch the input word
    logic              tick_inc;   // saturating count increment
    logic              rd_head;    // read queue head
    logic              pop;        // move head entry into pending, read next
    logic              ins_start;  // load threshold, start walk at tail
    logic              shift;      // move read entry one slot up, step down
    logic              put;        // write new entry above walk index
    logic              emit;       // load output register
    logic              emit_pend;  // target from pending entry
    logic [KIND_W-1:0] emit_kind;
    logic              emit_last;
    logic              pend_clr;   // drop pending entry
  } tdwq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              imm;        // delay answers at once
    logic              full;
    logic              occ_zero;
    logic              due;        // read entry threshold <= count
    logic              entry_gt;   // read entry threshold > new threshold
    logic              rem_zero;   // insert walk has no entries left
    logic              pend_vld;
    logic              slot_free;  // output register can take a word
  } tdwq_sts_t;

endpackage

>>> sv/tick_delay_wakeup_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_delay_wakeup_queue: tick counter with sorted sleeper queue
// Keeps a saturating tick count and a queue of requesters ordered by wake
// time; answers time queries and delays, and wakes due sleepers on a tick.
// ----------------------------------------------------------------------------
// One word is taken at a time. A time query, an immediate reply or a
// queue-full reply passes through decode and reply. A queued delay walks
// down from the tail, the sorted insert moving each entry with a later
// threshold up one slot a cycle through the queue memory, which has one
// read and one write port. A tick increments the count, then the wake
// cascade reads the queue head once a cycle while the output slot is free.
// The input side is ready in idle even while a reply waits in the output
// register. The queue memory needs no clearing pass after reset.
module tick_delay_wakeup_queue #(
  parameter int unsigned DEPTH   = 32,
  parameter int unsigned ID_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tdwq_pkg::SDATA_W-1:0]   s_axis_tdata,  // requester, amount
  input  logic [tdwq_pkg::KIND_W-1:0]    s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tdwq_pkg::MDATA_W-1:0]   m_axis_tdata,  // target, time_value, pad
  output logic [tdwq_pkg::KIND_W-1:0]    m_axis_tuser,  // reply_kind
  output logic                           m_axis_tlast   // last
);
  import tdwq_pkg::*;

  tdwq_cmd_t         cmd;
  tdwq_sts_t         sts;
  logic [REQ_W-1:0]  out_target;
  logic [TIME_W-1:0] out_time;

  tdwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdwq_dp #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_kind_i    (s_axis_tuser),
    .in_req_i     (s_axis_tdata[REQ_W-1:0]),
    .in_amount_i  (s_axis_tdata[REQ_W +: AMOUNT_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_target_o (out_target),
    .out_kind_o   (m_axis_tuser),
    .out_time_o   (out_time),
    .out_last_o   (m_axis_tlast)
  );

  // Output word packing
  assign m_axis_tdata = {1'b0, out_time, out_target};

endmodule

>>> sv/tdwq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdwq_ctrl: sequencer of the tick delay wakeup queue
// Decodes each request and steps the datapath through replies, the wake
// cascade after a tick and the sorted insert walk.
// ----------------------------------------------------------------------------
module tdwq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tdwq_pkg::tdwq_sts_t sts_i,
  output tdwq_pkg::tdwq_cmd_t cmd_o
);
  import tdwq_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DECODE   = 3'd1;
  localparam logic [2:0] ST_REPLY    = 3'd2;
  localparam logic [2:0] ST_WAKE_CHK = 3'd3;
  localparam logic [2:0] ST_FLUSH    = 3'd4;
  localparam logic [2:0] ST_INS_CMP  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [KIND_W-1:0] rk_q, rk_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    rk_d    = rk_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.kind)
          KIND_TICK: begin
            cmd_o.tick_inc = 1'b1;
            cmd_o.rd_head  = 1'b1;
            state_d        = ST_WAKE_CHK;
          end
          KIND_QUERY: begin
            rk_d    = RK_TIME;
            state_d = ST_REPLY;
          end
          default: begin
            if (sts_i.imm) begin
              rk_d    = RK_WAKE;
              state_d = ST_REPLY;
            end else if (sts_i.full) begin
              rk_d    = RK_FULL;
              state_d = ST_REPLY;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = ST_INS_CMP;
            end
          end
        endcase
      end
      ST_REPLY: begin
        if (sts_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = rk_q;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      // head entry is due: hand the previous one out, keep this one pending
      ST_WAKE_CHK: begin
        if (!sts_i.occ_zero && sts_i.due) begin
          if (!sts_i.pend_vld || sts_i.slot_free) begin
            if (sts_i.pend_vld) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_pend = 1'b1;
              cmd_o.emit_kind = RK_WAKE;
            end
            cmd_o.pop = 1'b1;
          end
        end else begin
          state_d = ST_FLUSH;
        end
      end
      // the pending wake is the final one
      ST_FLUSH: begin
        if (!sts_i.pend_vld) begin
          state_d = ST_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_pend = 1'b1;
          cmd_o.emit_kind = RK_WAKE;
          cmd_o.emit_last = 1'b1;
          cmd_o.pend_clr  = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.rem_zero || !sts_i.entry_gt) begin
          cmd_o.put = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rk_q    <= RK_WAKE;
    end else begin
      state_q <= state_d;
      rk_q    <= rk_d;
    end
  end

`ifndef SYNTHESIS
  a_pop_only_when_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> (sts_i.due && !sts_i.occ_zero))
    else $error("pop of an entry that is not due");
  a_no_put_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECODE && sts_i.full) |-> !cmd_o.ins_start)
    else $error("insert started on a full queue");
  a_emit_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.emit_last) |=> (state_q == ST_IDLE))
    else $error("final word not followed by idle");
`endif

endmodule

>>> sv/tdwq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdwq_dp: datapath of the tick delay wakeup queue
// Tick counter, circular sorted queue memory with head, tail and count,
// insert walk registers, pending wake entry and the output register.
// ----------------------------------------------------------------------------
module tdwq_dp #(
  parameter int unsigned DEPTH   = 32,
  parameter int unsigned ID_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tdwq_pkg::tdwq_cmd_t            cmd_i,
  output tdwq_pkg::tdwq_sts_t            sts_o,
  input  logic [tdwq_pkg::KIND_W-1:0]    in_kind_i,
  input  logic [tdwq_pkg::REQ_W-1:0]     in_req_i,
  input  logic [tdwq_pkg::AMOUNT_W-1:0]  in_amount_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tdwq_pkg::REQ_W-1:0]     out_target_o,
  output logic [tdwq_pkg::KIND_W-1:0]    out_kind_o,
  output logic [tdwq_pkg::TIME_W-1:0]    out_time_o,
  output logic                           out_last_o
);
  import tdwq_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned EW = TIME_W + ID_BITS;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : PW'(p - 1'b1);
  endfunction

  // Captured request
  logic [KIND_W-1:0]   kind_q;
  logic [REQ_W-1:0]    req_q;
  logic [AMOUNT_W-1:0] amount_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= in_kind_i;
      req_q    <= in_req_i;
      amount_q <= in_amount_i;
    end
  end

  // Tick counter, saturating
  logic [TIME_W-1:0] tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (cmd_i.tick_inc && (tick_q != '1)) begin
      tick_q <= tick_q + 1'b1;
    end
  end

  // Threshold and immediate answer
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] thr_new;
  logic              imm;

  assign sum     = {1'b0, tick_q} + {1'b0, amount_q[TIME_W-1:0]};
  assign thr_new = (kind_q == KIND_DELAY) ? (sum[TIME_W] ? '1 : sum[TIME_W-1:0])
                                          : amount_q[TIME_W-1:0];
  assign imm     = amount_q[AMOUNT_W-1] ||
                   ((kind_q == KIND_DELAY) ? (amount_q == '0)
                                           : (amount_q[TIME_W-1:0] <= tick_q));

  // Queue pointers and walk registers
  logic [PW-1:0]     head_q, tail_q, idx_q;
  logic [OW-1:0]     occ_q, rem_q;
  logic [TIME_W-1:0] thr_q;
  logic [ID_BITS-1:0] id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else begin
      if (cmd_i.pop) begin
        head_q <= ptr_inc(head_q);
        occ_q  <= occ_q - 1'b1;
      end
      if (cmd_i.put) begin
        tail_q <= ptr_inc(tail_q);
        occ_q  <= occ_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_start) begin
      idx_q <= ptr_dec(tail_q);
      rem_q <= occ_q;
      thr_q <= thr_new;
      id_q  <= ID_BITS'(req_q);
    end else if (cmd_i.shift) begin
      idx_q <= ptr_dec(idx_q);
      rem_q <= rem_q - 1'b1;
    end
  end

  // Queue memory, one read and one write port
  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_q;
  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  always_comb begin
    rd_addr = head_q;
    if (cmd_i.pop) begin
      rd_addr = ptr_inc(head_q);
    end else if (cmd_i.ins_start) begin
      rd_addr = ptr_dec(tail_q);
    end else if (cmd_i.shift) begin
      rd_addr = ptr_dec(idx_q);
    end
  end

  assign rd_en   = cmd_i.rd_head | cmd_i.pop | cmd_i.ins_start | cmd_i.shift;
  assign wr_en   = cmd_i.shift | cmd_i.put;
  assign wr_addr = ptr_inc(idx_q);
  assign wr_data = cmd_i.shift ? rd_q : {thr_q, id_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  logic [TIME_W-1:0] rd_thr;
  assign rd_thr = rd_q[ID_BITS +: TIME_W];

  // Pending wake entry
  logic               pend_vld_q;
  logic [ID_BITS-1:0] pend_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else if (cmd_i.pop) begin
      pend_vld_q <= 1'b1;
    end else if (cmd_i.pend_clr) begin
      pend_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      pend_id_q <= rd_q[ID_BITS-1:0];
    end
  end

  // Output register
  logic               out_vld_q;
  logic [REQ_W-1:0]   out_target_q;
  logic [KIND_W-1:0]  out_kind_q;
  logic [TIME_W-1:0]  out_time_q;
  logic               out_last_q;
  logic               slot_free;

  assign slot_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_target_q <= cmd_i.emit_pend ? REQ_W'(pend_id_q) : req_q;
      out_kind_q   <= cmd_i.emit_kind;
      out_time_q   <= (cmd_i.emit_kind == RK_TIME) ? tick_q : '0;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_target_o = out_target_q;
  assign out_kind_o   = out_kind_q;
  assign out_time_o   = out_time_q;
  assign out_last_o   = out_last_q;

  // Status
  always_comb begin
    sts_o           = '0;
    sts_o.kind      = kind_q;
    sts_o.imm       = imm;
    sts_o.full      = (occ_q == OW'(DEPTH));
    sts_o.occ_zero  = (occ_q == '0);
    sts_o.due       = (rd_thr <= tick_q);
    sts_o.entry_gt  = (rd_thr > thr_q);
    sts_o.rem_zero  = (rem_q == '0);
    sts_o.pend_vld  = pend_vld_q;
    sts_o.slot_free = slot_free;
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(DEPTH))
    else $error("occupancy above depth");
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> slot_free)
    else $error("output register overwritten");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (occ_q != '0))
    else $error("pop from empty queue");
  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put |-> (occ_q != OW'(DEPTH)))
    else $error("write into full queue");
  a_tick_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_inc |=> (tick_q != '0))
    else $error("tick count did not advance");
`endif

endmodule
